FILE: rtl/vbrf_pkg.sv
`default_nettype none

package vbrf_pkg;

	localparam int RING_BYTES = 4096;
	localparam int MAX_BLOCKS = 64;

	localparam int BYTE_AW = $clog2(RING_BYTES);
	localparam int LEN_W   = BYTE_AW + 1;
	localparam int DESC_AW = $clog2(MAX_BLOCKS);
	localparam int CNT_W   = DESC_AW + 1;

	typedef enum logic [1:0] {
		CMD_PUSH    = 2'd0,
		CMD_POP     = 2'd1,
		CMD_POP_CLR = 2'd2,
		CMD_READ    = 2'd3
	} cmd_t;

	// One write and one read access per cycle on the byte ring.
	typedef struct packed {
		logic               we;
		logic [BYTE_AW-1:0] waddr;
		logic [7:0]         wdata;
		logic               re;
		logic [BYTE_AW-1:0] raddr;
	} byte_req_t;

	// One write and one read access per cycle on the length queue.
	typedef struct packed {
		logic               we;
		logic [DESC_AW-1:0] waddr;
		logic [LEN_W-1:0]   wdata;
		logic               re;
		logic [DESC_AW-1:0] raddr;
	} desc_req_t;

endpackage

`default_nettype wire

FILE: rtl/variable_block_ring_fifo.sv
`default_nettype none

// Byte ring buffer that queues variable-length blocks in FIFO order.
// Command channel: an item is transferred on a rising edge with start high and busy
// low. cmd selects push byte, pop front block, pop front block with its bytes
// cleared to zero, or read one byte of the front block at read_offset.
// Result channel: every item yields exactly one result, shown for one cycle while
// done is high. The receiver cannot stall, so the result is taken in that cycle.
// The status fields (front block start, length, wrap spans, bytes used, block
// count) describe the buffer after the command.
// Sequence: a push runs through the execute state only and is then ready for the next
// transfer. A pop that leaves blocks behind and an in-range read add a fetch or read
// wait state, because the next front length or the byte comes out of a synchronous
// RAM. A pop that empties the buffer, any pop on an empty buffer and an out-of-range
// read finish in the execute state. A cleared pop of a block first walks the clear
// state over that block, since the clear sequencer writes one zero byte per cycle.
// Configuration: cfg_we with cfg_data writes the ring capacity (0 acts as 1, values
// above the ring size act as the ring size) and empties the buffer, including any
// partly pushed block. Write it only while no command is in flight; a command
// transferred at the same edge runs on the emptied buffer.
// Reset: arst_n low empties the buffer and sets the capacity to the full ring.

module variable_block_ring_fifo
	import vbrf_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [1:0]          cmd,
	input  wire logic [7:0]          data_byte,
	input  wire logic                block_end,
	input  wire logic [BYTE_AW-1:0]  read_offset,
	input  wire logic                cfg_we,
	input  wire logic [LEN_W-1:0]    cfg_data,
	output logic                     done,
	output logic                     ok,
	output logic [7:0]               read_data,
	output logic [BYTE_AW-1:0]       front_start,
	output logic [LEN_W-1:0]         front_length,
	output logic [LEN_W-1:0]         span_before_wrap,
	output logic [BYTE_AW-1:0]       span_after_wrap,
	output logic [LEN_W-1:0]         used_bytes,
	output logic [CNT_W-1:0]         block_count
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_CLEAR,
		ST_FETCH,
		ST_RDWAIT
	} state_t;

	state_t st_q;

	// Latched command.
	cmd_t               cmd_q;
	logic [7:0]         data_q;
	logic               last_q;
	logic [BYTE_AW-1:0] off_q;

	// Buffer bookkeeping. front_len_q caches the length at the queue head so that
	// the result fields never wait on a descriptor read.
	logic [LEN_W-1:0]   cap_q;
	logic [BYTE_AW-1:0] head_q;
	logic [LEN_W-1:0]   committed_q;
	logic [LEN_W-1:0]   pend_len_q;
	logic               pend_ovf_q;
	logic [DESC_AW-1:0] dhead_q;
	logic [CNT_W-1:0]   dcount_q;
	logic [LEN_W-1:0]   front_len_q;

	// Clear sequencer.
	logic [BYTE_AW-1:0] clr_addr_q;
	logic [LEN_W-1:0]   clr_left_q;

	// Result registers.
	logic               done_q;
	logic               ok_q;
	logic [7:0]         rdata_q;

	byte_req_t          byte_req;
	desc_req_t          desc_req;
	logic [7:0]         byte_rdata;
	logic [LEN_W-1:0]   desc_rdata;

	logic [LEN_W-1:0]   len_eff;
	logic [LEN_W-1:0]   span0;
	logic [LEN_W-1:0]   span1;
	logic [LEN_W:0]     fill_sum;
	logic [LEN_W:0]     wr_sum;
	logic [LEN_W:0]     wr_wrap;
	logic               fits;
	logic [LEN_W-1:0]   pend_next;
	logic               ovf_next;
	logic               commit;
	logic [LEN_W-1:0]   drop_sum;
	logic [BYTE_AW-1:0] head_next;
	logic [LEN_W-1:0]   committed_next;
	logic [LEN_W-1:0]   rd_sum;
	logic [BYTE_AW-1:0] rd_addr;
	logic               rd_ok;
	logic [LEN_W-1:0]   clr_inc;
	logic [BYTE_AW-1:0] clr_next;
	logic               drop_now;
	logic               result_now;
	logic [LEN_W-1:0]   cap_cfg;

	always_comb begin
		// Status view of the front block; the span split uses the active capacity.
		len_eff = (dcount_q != '0) ? front_len_q : '0;
		span0   = cap_q - {1'b0, head_q};
		if (len_eff < span0) begin
			span0 = len_eff;
		end
		span1 = len_eff - span0;

		// Push: the tail sits at head + committed + pending, wrapped once at the
		// capacity. It is only used when the byte fits, so it stays below twice
		// the capacity.
		fill_sum  = {1'b0, committed_q} + {1'b0, pend_len_q};
		fits      = !pend_ovf_q && (fill_sum < {1'b0, cap_q});
		wr_sum    = {2'b00, head_q} + fill_sum;
		wr_wrap   = (wr_sum >= {1'b0, cap_q}) ? (wr_sum - {1'b0, cap_q}) : wr_sum;
		pend_next = pend_len_q + LEN_W'(fits);
		ovf_next  = pend_ovf_q | !fits;
		commit    = last_q && !ovf_next && (pend_next != '0)
			&& (dcount_q < CNT_W'(MAX_BLOCKS));

		// Dropping the front block advances the head by its length.
		drop_sum       = {1'b0, head_q} + front_len_q;
		head_next      = (drop_sum >= cap_q) ? BYTE_AW'(drop_sum - cap_q)
			: drop_sum[BYTE_AW-1:0];
		committed_next = (committed_q >= front_len_q) ? (committed_q - front_len_q) : '0;

		// Read of one byte inside the front block.
		rd_ok   = (dcount_q != '0) && ({1'b0, off_q} < front_len_q);
		rd_sum  = {1'b0, head_q} + {1'b0, off_q};
		rd_addr = (rd_sum >= cap_q) ? BYTE_AW'(rd_sum - cap_q) : rd_sum[BYTE_AW-1:0];

		// The clear walk restarts at ring offset zero when it reaches the capacity.
		clr_inc  = {1'b0, clr_addr_q} + LEN_W'(1);
		clr_next = (clr_inc == cap_q) ? '0 : clr_inc[BYTE_AW-1:0];

		drop_now = ((st_q == ST_EXEC) && (cmd_q == CMD_POP) && (dcount_q != '0))
			|| ((st_q == ST_CLEAR) && (clr_left_q == LEN_W'(1)));

		// The result strobe follows the edge that finishes the command: a push, a
		// pop or cleared pop with no next front to fetch, a read that misses, the
		// descriptor fetch and the byte read wait.
		result_now = ((st_q == ST_EXEC) && ((cmd_q == CMD_PUSH)
				|| ((cmd_q == CMD_POP) && (dcount_q <= CNT_W'(1)))
				|| ((cmd_q == CMD_POP_CLR) && (dcount_q == '0))
				|| ((cmd_q == CMD_READ) && !rd_ok)))
			|| ((st_q == ST_CLEAR) && (clr_left_q == LEN_W'(1))
				&& (dcount_q <= CNT_W'(1)))
			|| (st_q == ST_FETCH) || (st_q == ST_RDWAIT);

		// Byte RAM: pushes and clears write, reads read. They never share a cycle
		// with a read of the same item, so no forwarding is needed.
		byte_req.we    = ((st_q == ST_EXEC) && (cmd_q == CMD_PUSH) && fits)
			|| (st_q == ST_CLEAR);
		byte_req.waddr = (st_q == ST_CLEAR) ? clr_addr_q : wr_wrap[BYTE_AW-1:0];
		byte_req.wdata = (st_q == ST_CLEAR) ? 8'h00 : data_q;
		byte_req.re    = (st_q == ST_EXEC) && (cmd_q == CMD_READ) && rd_ok;
		byte_req.raddr = rd_addr;

		// Length queue: a commit writes at the tail; a drop fetches the next front.
		desc_req.we    = (st_q == ST_EXEC) && (cmd_q == CMD_PUSH) && commit;
		desc_req.waddr = dhead_q + dcount_q[DESC_AW-1:0];
		desc_req.wdata = pend_next;
		desc_req.re    = drop_now && (dcount_q > CNT_W'(1));
		desc_req.raddr = dhead_q + DESC_AW'(1);

		if (cfg_data == '0) begin
			cap_cfg = LEN_W'(1);
		end else if (cfg_data > LEN_W'(RING_BYTES)) begin
			cap_cfg = LEN_W'(RING_BYTES);
		end else begin
			cap_cfg = cfg_data;
		end
	end

	vbrf_byte_ram u_byte_ram (
		.clk   (clk),
		.req   (byte_req),
		.rdata (byte_rdata)
	);

	vbrf_desc_ram u_desc_ram (
		.clk   (clk),
		.req   (desc_req),
		.rdata (desc_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			cmd_q       <= CMD_PUSH;
			data_q      <= '0;
			last_q      <= 1'b0;
			off_q       <= '0;
			cap_q       <= LEN_W'(RING_BYTES);
			head_q      <= '0;
			committed_q <= '0;
			pend_len_q  <= '0;
			pend_ovf_q  <= 1'b0;
			dhead_q     <= '0;
			dcount_q    <= '0;
			front_len_q <= '0;
			clr_addr_q  <= '0;
			clr_left_q  <= '0;
			done_q      <= 1'b0;
			ok_q        <= 1'b0;
			rdata_q     <= '0;
		end else begin
			done_q <= result_now;

			if (drop_now) begin
				head_q      <= head_next;
				committed_q <= committed_next;
				dhead_q     <= dhead_q + DESC_AW'(1);
				dcount_q    <= dcount_q - CNT_W'(1);
			end

			unique case (st_q)
				ST_IDLE: begin
					// A capacity write empties the buffer first; a command taken at
					// the same edge then runs on the empty buffer.
					if (cfg_we) begin
						cap_q       <= cap_cfg;
						head_q      <= '0;
						committed_q <= '0;
						pend_len_q  <= '0;
						pend_ovf_q  <= 1'b0;
						dhead_q     <= '0;
						dcount_q    <= '0;
					end
					if (start) begin
						cmd_q  <= cmd_t'(cmd);
						data_q <= data_byte;
						last_q <= block_end;
						off_q  <= read_offset;
						st_q   <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					unique case (cmd_q)
						CMD_PUSH: begin
							if (last_q) begin
								pend_len_q <= '0;
								pend_ovf_q <= 1'b0;
								if (commit) begin
									committed_q <= committed_q + pend_next;
									dcount_q    <= dcount_q + CNT_W'(1);
									if (dcount_q == '0) begin
										front_len_q <= pend_next;
									end
								end
							end else begin
								pend_len_q <= pend_next;
								pend_ovf_q <= ovf_next;
							end
							ok_q    <= commit;
							rdata_q <= '0;
							st_q    <= ST_IDLE;
						end
						CMD_POP: begin
							ok_q    <= (dcount_q != '0);
							rdata_q <= '0;
							if (dcount_q > CNT_W'(1)) begin
								st_q <= ST_FETCH;
							end else begin
								st_q <= ST_IDLE;
							end
						end
						CMD_POP_CLR: begin
							ok_q    <= (dcount_q != '0);
							rdata_q <= '0;
							if (dcount_q != '0) begin
								clr_addr_q <= head_q;
								clr_left_q <= front_len_q;
								st_q       <= ST_CLEAR;
							end else begin
								st_q <= ST_IDLE;
							end
						end
						CMD_READ: begin
							ok_q    <= rd_ok;
							rdata_q <= '0;
							if (rd_ok) begin
								st_q <= ST_RDWAIT;
							end else begin
								st_q <= ST_IDLE;
							end
						end
						default: begin
							st_q <= ST_IDLE;
						end
					endcase
				end
				ST_CLEAR: begin
					clr_addr_q <= clr_next;
					clr_left_q <= clr_left_q - LEN_W'(1);
					if (clr_left_q == LEN_W'(1)) begin
						if (dcount_q > CNT_W'(1)) begin
							st_q <= ST_FETCH;
						end else begin
							st_q <= ST_IDLE;
						end
					end
				end
				ST_FETCH: begin
					front_len_q <= desc_rdata;
					st_q        <= ST_IDLE;
				end
				ST_RDWAIT: begin
					rdata_q <= byte_rdata;
					st_q    <= ST_IDLE;
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy             = (st_q != ST_IDLE);
	assign done             = done_q;
	assign ok               = ok_q;
	assign read_data        = rdata_q;
	assign front_start      = head_q;
	assign front_length     = len_eff;
	assign span_before_wrap = span0;
	assign span_after_wrap  = span1[BYTE_AW-1:0];
	assign used_bytes       = committed_q;
	assign block_count      = dcount_q;

`ifndef SYNTHESIS
	// Every command passes through at least the execute state, so results never come back to back.
	assert property (@(posedge clk) disable iff (!arst_n) done_q |=> !done_q)
		else $error("result strobe held for two cycles");

	// A transferred command always makes the block busy in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy && !cfg_we) |=> busy)
		else $error("command transfer did not start work");

	// The queue never holds more blocks than it has descriptor slots.
	assert property (@(posedge clk) disable iff (!arst_n) dcount_q <= CNT_W'(MAX_BLOCKS))
		else $error("descriptor count overflow");

	// Committed bytes fit in the ring, and the head stays inside it.
	assert property (@(posedge clk) disable iff (!arst_n)
		(committed_q <= cap_q) && ({1'b0, head_q} < cap_q))
		else $error("ring bookkeeping out of range");

	// A cleared pop walks exactly the front block and then drops it.
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_CLEAR && clr_left_q == LEN_W'(1)) |=> (st_q != ST_CLEAR))
		else $error("clear sequencer overran the block");
`endif

endmodule

`default_nettype wire

FILE: rtl/vbrf_byte_ram.sv
`default_nettype none

module vbrf_byte_ram
	import vbrf_pkg::*;
(
	input  wire logic      clk,
	input  wire byte_req_t req,
	output logic [7:0]     rdata
);

	logic [7:0] mem [RING_BYTES];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/vbrf_desc_ram.sv
`default_nettype none

module vbrf_desc_ram
	import vbrf_pkg::*;
(
	input  wire logic       clk,
	input  wire desc_req_t  req,
	output logic [LEN_W-1:0] rdata
);

	logic [LEN_W-1:0] mem [MAX_BLOCKS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

`default_nettype wire

FILE: bench/variable_block_ring_fifo_test.sv
module variable_block_ring_fifo_test;
	import vbrf_pkg::*;

	// A generous ceiling on the run length. The slowest legal run stays under
	// it: about 850 commands, each with at most one idle gap and a cleared
	// pop of at most one hundred bytes, plus a handful of capacity writes.
	localparam int CYCLE_LIMIT = 600000;

	// Depth of the list of predicted results; one command is in flight at a time.
	localparam int EXP_DEPTH = 8;

	// Expected result of one command. The fields mirror the result ports.
	typedef struct packed {
		logic               ok;
		logic [7:0]         read_data;
		logic [BYTE_AW-1:0] front_start;
		logic [LEN_W-1:0]   front_length;
		logic [LEN_W-1:0]   span_before_wrap;
		logic [BYTE_AW-1:0] span_after_wrap;
		logic [LEN_W-1:0]   used_bytes;
		logic [CNT_W-1:0]   block_count;
	} ring_status_t;

	// Every input has a known value from time zero on.
	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               start       = 1'b0;
	logic [1:0]         cmd         = CMD_READ;
	logic [7:0]         data_byte   = '0;
	logic               block_end   = 1'b0;
	logic [BYTE_AW-1:0] read_offset = '0;
	logic               cfg_we      = 1'b0;
	logic [LEN_W-1:0]   cfg_data    = '0;

	logic               busy;
	logic               done;
	logic               ok;
	logic [7:0]         read_data;
	logic [BYTE_AW-1:0] front_start;
	logic [LEN_W-1:0]   front_length;
	logic [LEN_W-1:0]   span_before_wrap;
	logic [BYTE_AW-1:0] span_after_wrap;
	logic [LEN_W-1:0]   used_bytes;
	logic [CNT_W-1:0]   block_count;

	variable_block_ring_fifo dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.cmd              (cmd),
		.data_byte        (data_byte),
		.block_end        (block_end),
		.read_offset      (read_offset),
		.cfg_we           (cfg_we),
		.cfg_data         (cfg_data),
		.done             (done),
		.ok               (ok),
		.read_data        (read_data),
		.front_start      (front_start),
		.front_length     (front_length),
		.span_before_wrap (span_before_wrap),
		.span_after_wrap  (span_after_wrap),
		.used_bytes       (used_bytes),
		.block_count      (block_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the ring buffer. Byte entries that were never written
	// stay X; the stimulus only reads bytes of committed blocks, so an X never
	// reaches an expected result.
	logic [7:0]         ring_mem [RING_BYTES];
	int                 len_fifo [MAX_BLOCKS];
	logic [LEN_W-1:0]   cap_reg   = LEN_W'(RING_BYTES);
	int                 head      = 0;
	int                 used      = 0;
	int                 pend_len  = 0;
	bit                 pend_ovf  = 1'b0;
	int                 desc_rd   = 0;
	int                 desc_num  = 0;

	// Results predicted for transferred commands, oldest first. The sender
	// advances exp_wr and the checker advances exp_rd.
	ring_status_t       exp_buf [EXP_DEPTH];
	int                 exp_wr       = 0;
	int                 exp_rd       = 0;

	int                 idle_pct     = 0;
	int                 bytes_left   = 0;
	int                 n_commands   = 0;
	int                 n_results    = 0;
	int                 n_mismatches = 0;
	int                 n_committed  = 0;
	int                 n_dropped    = 0;
	int                 n_pops       = 0;
	int                 n_cap_writes = 0;
	int                 cycle_count  = 0;

	// Capacity as the block applies it: zero acts as one byte and anything
	// above the ring size acts as the ring size.
	function automatic int eff_capacity();
		if (cap_reg == 0)
			return 1;
		if (cap_reg > RING_BYTES)
			return RING_BYTES;
		return int'(cap_reg);
	endfunction

	function automatic int front_len_now();
		return (desc_num > 0) ? len_fifo[desc_rd] : 0;
	endfunction

	// Advances the shadow buffer by one command and returns the status the
	// block must report for it.
	task automatic predict_status(input cmd_t c, input logic [7:0] d, input logic last,
			input logic [BYTE_AW-1:0] offs, output ring_status_t r);
		int cap;
		int len;
		int s0;
		int s1;
		int slot;
		cap = eff_capacity();
		r = '0;
		case (c)
			CMD_PUSH: begin
				// A byte that does not fit is lost and poisons the rest of its block.
				if (!pend_ovf && used + pend_len < cap) begin
					ring_mem[(head + used + pend_len) % cap] = d;
					pend_len++;
				end else begin
					pend_ovf = 1'b1;
				end
				if (last) begin
					if (!pend_ovf && pend_len > 0 && desc_num < MAX_BLOCKS) begin
						slot = (desc_rd + desc_num) % MAX_BLOCKS;
						len_fifo[slot] = pend_len;
						used += pend_len;
						desc_num++;
						r.ok = 1'b1;
						n_committed++;
					end else begin
						n_dropped++;
					end
					pend_len = 0;
					pend_ovf = 1'b0;
				end
			end
			CMD_POP, CMD_POP_CLR: begin
				if (desc_num > 0) begin
					len = front_len_now();
					if (c == CMD_POP_CLR) begin
						// The part past the ring end restarts at offset zero.
						s0 = cap - head;
						if (len < s0)
							s0 = len;
						s1 = len - s0;
						if (s1 > cap)
							s1 = cap;
						for (int i = 0; i < s0; i++)
							ring_mem[(head + i) % RING_BYTES] = 8'h00;
						for (int i = 0; i < s1; i++)
							ring_mem[i % RING_BYTES] = 8'h00;
					end
					head = (head + len) % cap;
					used = (used >= len) ? used - len : 0;
					desc_rd = (desc_rd + 1) % MAX_BLOCKS;
					desc_num--;
					r.ok = 1'b1;
					n_pops++;
				end
			end
			CMD_READ: begin
				if (int'(offs) < front_len_now()) begin
					r.read_data = ring_mem[(head + int'(offs)) % cap];
					r.ok = 1'b1;
				end
			end
		endcase
		len = front_len_now();
		s0 = cap - head;
		if (len < s0)
			s0 = len;
		s1 = len - s0;
		r.front_start      = BYTE_AW'(head);
		r.front_length     = LEN_W'(len);
		r.span_before_wrap = LEN_W'(s0);
		r.span_after_wrap  = BYTE_AW'(s1);
		r.used_bytes       = LEN_W'(used);
		r.block_count      = CNT_W'(desc_num);
	endtask

	// Presents one command and holds it until the block takes it. When the
	// sender is set to idle, start drops for a random gap first, so that the
	// gap lands on a different phase of the previous command each time.
	task automatic send_item(input cmd_t c, input logic [7:0] d, input logic last,
			input logic [BYTE_AW-1:0] offs);
		ring_status_t exp_status;
		int gap;
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			gap = $urandom_range(1, 5);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		cmd         <= c;
		data_byte   <= d;
		block_end   <= last;
		read_offset <= offs;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		// The transfer happened at this edge.
		predict_status(c, d, last, offs, exp_status);
		exp_buf[exp_wr % EXP_DEPTH] = exp_status;
		exp_wr++;
		n_commands++;
	endtask

	// Drains the block, then writes the capacity register. The write empties
	// the buffer, including any partly pushed block.
	task automatic write_capacity(input int value);
		start <= 1'b0;
		while (exp_wr != exp_rd)
			@(posedge clk);
		repeat (3) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= LEN_W'(value);
		@(posedge clk);
		cfg_we   <= 1'b0;
		cap_reg    = LEN_W'(value);
		head       = 0;
		used       = 0;
		pend_len   = 0;
		pend_ovf   = 1'b0;
		desc_rd    = 0;
		desc_num   = 0;
		bytes_left = 0;
		n_cap_writes++;
	endtask

	function automatic logic [BYTE_AW-1:0] any_offset();
		return BYTE_AW'($urandom_range(0, RING_BYTES - 1));
	endfunction

	function automatic logic [7:0] any_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	// Pops, cleared pops and reads on an empty buffer.
	task automatic test_empty_buffer();
		send_item(CMD_POP, 8'h00, 1'b0, '0);
		send_item(CMD_POP_CLR, 8'hFF, 1'b1, '1);
		send_item(CMD_READ, 8'h00, 1'b0, '0);
	endtask

	// Extreme byte values, reads at the edges of the front block and past it,
	// and a cleared pop that exposes the next block.
	task automatic test_basic_blocks();
		send_item(CMD_PUSH, 8'h00, 1'b0, '1);
		send_item(CMD_PUSH, 8'hFF, 1'b0, '0);
		send_item(CMD_PUSH, 8'hA5, 1'b1, '0);
		send_item(CMD_READ, 8'h00, 1'b0, BYTE_AW'(0));
		send_item(CMD_READ, 8'h00, 1'b0, BYTE_AW'(2));
		send_item(CMD_READ, 8'h00, 1'b0, BYTE_AW'(3));
		send_item(CMD_READ, 8'hFF, 1'b1, '1);
		send_item(CMD_PUSH, 8'h5A, 1'b1, '0);
		send_item(CMD_POP_CLR, 8'h00, 1'b0, '0);
		send_item(CMD_READ, 8'h00, 1'b0, BYTE_AW'(0));
		send_item(CMD_POP, 8'h00, 1'b0, '0);
	endtask

	// A capacity of zero acts as a one-byte ring: the second block cannot fit.
	task automatic test_tiny_ring();
		write_capacity(0);
		send_item(CMD_PUSH, 8'h11, 1'b1, '0);
		send_item(CMD_PUSH, 8'h22, 1'b1, '0);
		send_item(CMD_READ, 8'h00, 1'b0, BYTE_AW'(0));
		send_item(CMD_POP, 8'h00, 1'b0, '0);
	endtask

	// A capacity write in the middle of a block throws the partial block
	// away. Then a block that runs past the ring end is read on both sides of
	// the wrap and popped with clearing.
	task automatic test_wrapped_block();
		write_capacity(5);
		send_item(CMD_PUSH, 8'hC1, 1'b0, '0);
		send_item(CMD_PUSH, 8'hC2, 1'b0, '0);
		write_capacity(5);
		for (int i = 0; i < 3; i++)
			send_item(CMD_PUSH, 8'(8'h30 + i), i == 2, '0);
		send_item(CMD_POP, 8'h00, 1'b0, '0);
		for (int i = 0; i < 4; i++)
			send_item(CMD_PUSH, 8'(8'h40 + i), i == 3, '0);
		send_item(CMD_READ, 8'h00, 1'b0, BYTE_AW'(1));
		send_item(CMD_READ, 8'h00, 1'b0, BYTE_AW'(3));
		send_item(CMD_POP_CLR, 8'h00, 1'b0, '0);
	endtask

	// An oversized capacity value acts as the full ring; a long block there
	// is read at its last byte and popped with clearing. Then one block fills
	// a small ring, a further block is dropped, and the full block is
	// cleared. A last block leaves the head away from zero for the traffic
	// that follows.
	task automatic test_largest_block();
		write_capacity((1 << LEN_W) - 1);
		for (int i = 0; i < 100; i++)
			send_item(CMD_PUSH, any_byte(), i == 99, any_offset());
		send_item(CMD_READ, 8'h00, 1'b0, BYTE_AW'(99));
		send_item(CMD_POP_CLR, 8'h00, 1'b0, '0);
		write_capacity(48);
		for (int i = 0; i < 48; i++)
			send_item(CMD_PUSH, any_byte(), i == 47, any_offset());
		send_item(CMD_READ, 8'h00, 1'b0, BYTE_AW'(47));
		send_item(CMD_PUSH, 8'h77, 1'b1, '0);
		send_item(CMD_POP_CLR, 8'h00, 1'b0, '0);
		for (int i = 0; i < 30; i++)
			send_item(CMD_PUSH, any_byte(), i == 29, any_offset());
		send_item(CMD_POP, 8'h00, 1'b0, '0);
	endtask

	// Mostly short blocks, with now and then one larger than the free space.
	function automatic int pick_length(input int max_len);
		int hi;
		if ($urandom_range(0, 9) != 0)
			return $urandom_range(1, max_len);
		hi = eff_capacity() + 2;
		if (hi > 4 * max_len)
			hi = 4 * max_len;
		return $urandom_range(1, hi);
	endfunction

	// Random traffic made mostly of well-formed blocks with random contents,
	// mixed with pops, reads inside and outside the front block, and stray
	// pushes that end or extend blocks out of turn. Pops on an empty buffer
	// are sent but not counted, since they leave the buffer as it is.
	task automatic test_random_traffic(input int n_items, input int idle, input int pop_pct,
			input int max_len);
		int counted;
		int pick;
		int len;
		cmd_t c;
		idle_pct = idle;
		counted = 0;
		while (counted < n_items) begin
			pick = $urandom_range(0, 99);
			if (bytes_left == 0 && pick < 40)
				bytes_left = pick_length(max_len);
			if (bytes_left > 0 && pick >= 4) begin
				bytes_left--;
				send_item(CMD_PUSH, any_byte(), bytes_left == 0, any_offset());
				counted++;
			end else if ($urandom_range(0, 99) < pop_pct) begin
				c = $urandom_range(0, 1) ? CMD_POP_CLR : CMD_POP;
				if (desc_num > 0)
					counted++;
				send_item(c, any_byte(), 1'($urandom_range(0, 1)), any_offset());
			end else begin
				pick = $urandom_range(0, 9);
				len = front_len_now();
				if (pick < 6 && len > 0)
					send_item(CMD_READ, any_byte(), 1'($urandom_range(0, 1)),
						BYTE_AW'($urandom_range(0, len - 1)));
				else if (pick < 8)
					send_item(CMD_READ, any_byte(), 1'($urandom_range(0, 1)), any_offset());
				else
					send_item(CMD_PUSH, any_byte(), 1'($urandom_range(0, 1)), any_offset());
				counted++;
			end
		end
		idle_pct = 0;
	endtask

	// Checks every result strobe against the oldest prediction. done is read
	// at the edge that ends its cycle, before the block updates its outputs.
	always @(posedge clk) begin
		ring_status_t got;
		ring_status_t want;
		if (arst_n && done) begin
			got.ok               = ok;
			got.read_data        = read_data;
			got.front_start      = front_start;
			got.front_length     = front_length;
			got.span_before_wrap = span_before_wrap;
			got.span_after_wrap  = span_after_wrap;
			got.used_bytes       = used_bytes;
			got.block_count      = block_count;
			n_results++;
			if (exp_wr == exp_rd) begin
				if (n_mismatches < 10)
					$display("ERROR: result with no command waiting: ok=%0b rd=%02h",
						ok, read_data);
				n_mismatches++;
			end else begin
				want = exp_buf[exp_rd % EXP_DEPTH];
				exp_rd++;
				if (got.ok !== want.ok || got.read_data !== want.read_data ||
						got.front_start !== want.front_start ||
						got.front_length !== want.front_length ||
						got.span_before_wrap !== want.span_before_wrap ||
						got.span_after_wrap !== want.span_after_wrap ||
						got.used_bytes !== want.used_bytes ||
						got.block_count !== want.block_count) begin
					if (n_mismatches < 10) begin
						$display("ERROR: result %0d differs", n_results);
						$write("  expected ok=%0b rd=%02h start=%0d len=%0d",
							want.ok, want.read_data, want.front_start,
							want.front_length);
						$display(" s0=%0d s1=%0d used=%0d blocks=%0d",
							want.span_before_wrap, want.span_after_wrap,
							want.used_bytes, want.block_count);
						$write("  actual   ok=%0b rd=%02h start=%0d len=%0d",
							got.ok, got.read_data, got.front_start,
							got.front_length);
						$display(" s0=%0d s1=%0d used=%0d blocks=%0d",
							got.span_before_wrap, got.span_after_wrap,
							got.used_bytes, got.block_count);
					end
					n_mismatches++;
				end
			end
		end
	end

	// Watchdog: a missing result or a stuck busy ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding",
				cycle_count, exp_wr - exp_rd);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed checks first, all at the reset capacity unless they set one.
		test_empty_buffer();
		test_basic_blocks();
		test_tiny_ring();
		test_wrapped_block();
		test_largest_block();

		// Random phases. The first continues on the small ring left by the
		// directed checks, with its head away from zero; the others restart
		// from an empty ring at a new capacity. The one-byte blocks with rare
		// pops fill the descriptor queue so that commits are refused for lack
		// of a slot.
		test_random_traffic(120, 0, 45, 40);
		write_capacity(64);
		test_random_traffic(100, 72, 45, 24);
		write_capacity(1);
		test_random_traffic(40, 30, 45, 2);
		write_capacity(RING_BYTES);
		test_random_traffic(250, 0, 3, 1);
		write_capacity(17);
		test_random_traffic(90, 30, 45, 20);

		// Let the last results come out, then leave the block idle to show any stray strobe.
		start <= 1'b0;
		while (exp_wr != exp_rd)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d commands over %0d capacity settings and checked %0d results.",
			n_commands, n_cap_writes, n_results);
		$display("Blocks committed %0d, dropped %0d, popped %0d; mismatches %0d.",
			n_committed, n_dropped, n_pops, n_mismatches);
		if (n_mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
